### rtl/core/wmm_pkg.sv
// Shared constants, types and a helper function of the wildcard motif match counter.
`timescale 1ns / 1ps
package wmm_pkg;

    localparam int MOTIF_MAX_DEF    = 16;
    localparam int SEQUENCE_MAX_DEF = 4096;

    localparam int SYM_W      = 8;
    localparam int LEN_W      = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int TOTAL_W    = 32;
    localparam int SET_CNT_W  = 16;

    localparam logic [SYM_W-1:0] WILDCARD = 8'd45;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MOTIF_LOW  = 2'd0,
        REG_MOTIF_HIGH = 2'd1,
        REG_MOTIF_LEN  = 2'd2
    } wmm_reg_t;

    // Stage control handed from the symbol chain to the tally stage.
    typedef struct packed {
        logic valid;
        logic eos;
        logic eset;
    } wmm_ctl_t;

    // Motif character idx; characters beyond 15 read as zero.
    function automatic logic [SYM_W-1:0] motif_char(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [LEN_W-1:0] idx
    );
        logic [SYM_W-1:0] ch;
        ch = '0;
        case (idx[LEN_W-1:3])
            2'd0:    ch = lo[{idx[2:0], 3'b000} +: SYM_W];
            2'd1:    ch = hi[{idx[2:0], 3'b000} +: SYM_W];
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

### rtl/core/wmm_cell.sv
// One window cell: holds a symbol, hands it to its neighbor, compares it against its motif character.
`timescale 1ns / 1ps
module wmm_cell #(
    parameter int POS = 0
) (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  logic [wmm_pkg::SYM_W-1:0]  sym_in,
    input  logic [wmm_pkg::LEN_W-1:0]  motif_len,
    input  logic [wmm_pkg::CFG_W-1:0]  motif_lo,
    input  logic [wmm_pkg::CFG_W-1:0]  motif_hi,
    output logic [wmm_pkg::SYM_W-1:0]  sym_out,
    output logic                       match
);

    localparam logic [wmm_pkg::LEN_W:0] POS_EXT = (wmm_pkg::LEN_W + 1)'(POS);

    logic [wmm_pkg::SYM_W-1:0] sym_reg;
    logic [wmm_pkg::LEN_W:0]   idx_wide;
    logic                      in_use;
    logic [wmm_pkg::SYM_W-1:0] mchar;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sym_reg <= sym_in;
        end
    end

    // Cell POS (newest first) lines up with motif character len-1-POS.
    always_comb begin
        in_use   = {1'b0, motif_len} > POS_EXT;
        idx_wide = {1'b0, motif_len} - POS_EXT - (wmm_pkg::LEN_W + 1)'(1);
        mchar    = wmm_pkg::motif_char(motif_lo, motif_hi, idx_wide[wmm_pkg::LEN_W-1:0]);
        match    = !in_use || (mchar == wmm_pkg::WILDCARD) || (mchar == sym_reg);
    end

    assign sym_out = sym_reg;

endmodule

### rtl/core/wmm_tally.sv
// Hit tally stage: per-sequence and per-set counters plus the result register.
`timescale 1ns / 1ps
module wmm_tally #(
    parameter int SEQUENCE_MAX = wmm_pkg::SEQUENCE_MAX_DEF,
    parameter int HITS_W       = $clog2(SEQUENCE_MAX + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wmm_pkg::wmm_ctl_t             ctl,
    input  logic                          hit,
    output logic                          stall,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [HITS_W-1:0]             m_sequence_hits,
    output logic                          m_sequence_covered,
    output logic [wmm_pkg::TOTAL_W-1:0]   m_total_hits,
    output logic [wmm_pkg::SET_CNT_W-1:0] m_covered_sequences,
    output logic [wmm_pkg::SET_CNT_W-1:0] m_seen_sequences
);

    localparam logic [HITS_W-1:0] HITS_SAT = HITS_W'(SEQUENCE_MAX);

    logic [HITS_W-1:0]             hits_seq_reg, hits_seq_next;
    logic [wmm_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [wmm_pkg::SET_CNT_W-1:0] cov_reg, cov_next;
    logic [wmm_pkg::SET_CNT_W-1:0] seen_reg, seen_next;
    logic                          m_valid_reg, m_valid_next;

    logic [HITS_W-1:0]             hits_cur;
    logic [wmm_pkg::TOTAL_W:0]     sum_wide;
    logic [wmm_pkg::TOTAL_W-1:0]   total_new;
    logic [wmm_pkg::SET_CNT_W-1:0] cov_new;
    logic [wmm_pkg::SET_CNT_W-1:0] seen_new;
    logic                          covered;
    logic                          fire;
    logic                          report;

    always_comb begin
        stall  = ctl.valid && ctl.eos && m_valid_reg && !m_ready;
        fire   = ctl.valid && !stall;
        report = fire && ctl.eos;

        hits_cur = hits_seq_reg;
        if (hit && (hits_seq_reg != HITS_SAT)) begin
            hits_cur = hits_seq_reg + HITS_W'(1);
        end
        covered = (hits_cur != '0);

        sum_wide  = {1'b0, total_reg} + (wmm_pkg::TOTAL_W + 1)'(hits_cur);
        total_new = sum_wide[wmm_pkg::TOTAL_W] ? '1 : sum_wide[wmm_pkg::TOTAL_W-1:0];
        cov_new   = (covered && (cov_reg != '1)) ? cov_reg + 1'b1 : cov_reg;
        seen_new  = (seen_reg != '1) ? seen_reg + 1'b1 : seen_reg;

        hits_seq_next = hits_seq_reg;
        total_next    = total_reg;
        cov_next      = cov_reg;
        seen_next     = seen_reg;
        if (fire) begin
            hits_seq_next = ctl.eos ? '0 : hits_cur;
            if (ctl.eos) begin
                total_next = ctl.eset ? '0 : total_new;
                cov_next   = ctl.eset ? '0 : cov_new;
                seen_next  = ctl.eset ? '0 : seen_new;
            end
        end

        m_valid_next = m_valid_reg;
        if (report) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_seq_reg <= '0;
            total_reg    <= '0;
            cov_reg      <= '0;
            seen_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            hits_seq_reg <= hits_seq_next;
            total_reg    <= total_next;
            cov_reg      <= cov_next;
            seen_reg     <= seen_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (report) begin
            m_sequence_hits     <= hits_cur;
            m_sequence_covered  <= covered;
            m_total_hits        <= total_new;
            m_covered_sequences <= cov_new;
            m_seen_sequences    <= seen_new;
        end
    end

    assign m_valid = m_valid_reg;

    a_hits_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        hits_seq_reg <= HITS_SAT)
        else $error("sequence hit count above its limit");

    a_covered_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sequence_covered == (m_sequence_hits != '0)))
        else $error("covered flag disagrees with hit count");

    a_cov_le_seen : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_covered_sequences <= m_seen_sequences))
        else $error("covered sequences exceed seen sequences");

endmodule

### rtl/core/wildcard_motif_match_counter_unit.sv
// Top level of the wildcard motif match counter: config registers, symbol cell chain, tally stage.
// The unit streams the symbols of a set of sequences, one transaction per symbol, and counts
// every window of the current sequence that matches the configured motif (up to MOTIF_MAX
// characters; a dash, code 45, matches any symbol). Overlapping hits count, and a sequence
// shorter than the motif gives none. The symbol that carries end_of_sequence produces one
// result transaction with that sequence's hit count (saturating at SEQUENCE_MAX), a covered
// flag and saturating set totals; end_of_set on that symbol clears the totals after the
// report. The unit takes one symbol per clock while not stalled: symbols shift through a
// row of MOTIF_MAX cells, each comparing its own symbol against its motif character; the
// combined cell results are tallied and a result enters the output register when its
// end-of-sequence symbol is tallied. Input stalls only while a finished result waits in
// the output register, m_ready is low and the next end-of-sequence symbol is ready to
// report. Write the motif registers only while the unit is idle.
`timescale 1ns / 1ps
module wildcard_motif_match_counter_unit #(
    parameter int MOTIF_MAX    = wmm_pkg::MOTIF_MAX_DEF,
    parameter int SEQUENCE_MAX = wmm_pkg::SEQUENCE_MAX_DEF,
    parameter int HITS_W       = $clog2(SEQUENCE_MAX + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [wmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wmm_pkg::CFG_W-1:0]      cfg_wr_data,

    // symbol stream
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [wmm_pkg::SYM_W-1:0]      s_symbol,
    input  logic                           s_end_of_sequence,
    input  logic                           s_end_of_set,

    // per-sequence results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [HITS_W-1:0]              m_sequence_hits,
    output logic                           m_sequence_covered,
    output logic [wmm_pkg::TOTAL_W-1:0]    m_total_hits,
    output logic [wmm_pkg::SET_CNT_W-1:0]  m_covered_sequences,
    output logic [wmm_pkg::SET_CNT_W-1:0]  m_seen_sequences
);

    localparam int CNT_W = $clog2(MOTIF_MAX + 1);
    localparam logic [CNT_W-1:0]         CNT_SAT  = CNT_W'(MOTIF_MAX);
    localparam logic [wmm_pkg::LEN_W:0]  LEN_CAP  = (wmm_pkg::LEN_W + 1)'(MOTIF_MAX);

    // Configuration registers.
    logic [wmm_pkg::CFG_W-1:0] motif_lo_reg, motif_lo_next;
    logic [wmm_pkg::CFG_W-1:0] motif_hi_reg, motif_hi_next;
    logic [wmm_pkg::LEN_W-1:0] motif_len_reg, motif_len_next;
    logic [wmm_pkg::LEN_W-1:0] len_eff;

    // Window stage control.
    logic             stage_valid_reg, stage_valid_next;
    logic             stage_eos_reg, stage_eos_next;
    logic             stage_eset_reg, stage_eset_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_base;

    logic                      s_fire;
    logic                      stall;
    logic                      hit;
    logic [MOTIF_MAX-1:0]      cell_match;
    logic [wmm_pkg::SYM_W-1:0] chain [MOTIF_MAX+1];
    wmm_pkg::wmm_ctl_t         ctl;

    // Decode configuration writes; drop writes beyond the register list.
    always_comb begin
        motif_lo_next  = motif_lo_reg;
        motif_hi_next  = motif_hi_reg;
        motif_len_next = motif_len_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                wmm_pkg::REG_MOTIF_LOW:  motif_lo_next  = cfg_wr_data;
                wmm_pkg::REG_MOTIF_HIGH: motif_hi_next  = cfg_wr_data;
                wmm_pkg::REG_MOTIF_LEN:  motif_len_next = cfg_wr_data[wmm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motif_lo_reg  <= '0;
            motif_hi_reg  <= '0;
            motif_len_reg <= wmm_pkg::LEN_W'(1);
        end else begin
            motif_lo_reg  <= motif_lo_next;
            motif_hi_reg  <= motif_hi_next;
            motif_len_reg <= motif_len_next;
        end
    end

    // Clamp the motif length to the number of cells.
    assign len_eff = ({1'b0, motif_len_reg} > LEN_CAP) ? LEN_CAP[wmm_pkg::LEN_W-1:0]
                                                       : motif_len_reg;

    // Accept a symbol unless the tally stage is held by a full output register.
    assign s_ready = !stall;
    assign s_fire  = s_valid && s_ready;

    // Symbol count of the current sequence, restarting after an end-of-sequence symbol.
    always_comb begin
        count_base       = stage_eos_reg ? '0 : count_reg;
        count_next       = count_reg;
        stage_valid_next = stage_valid_reg && stall;
        stage_eos_next   = stage_eos_reg;
        stage_eset_next  = stage_eset_reg;
        if (s_fire) begin
            count_next       = (count_base == CNT_SAT) ? count_base : count_base + 1'b1;
            stage_valid_next = 1'b1;
            stage_eos_next   = s_end_of_sequence;
            stage_eset_next  = s_end_of_set;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            stage_eos_reg   <= 1'b0;
            stage_eset_reg  <= 1'b0;
            count_reg       <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            stage_eos_reg   <= stage_eos_next;
            stage_eset_reg  <= stage_eset_next;
            count_reg       <= count_next;
        end
    end

    // Row of window cells; cell 0 holds the newest symbol.
    assign chain[0] = s_symbol;

    for (genvar j = 0; j < MOTIF_MAX; j++) begin : g_cell
        wmm_cell #(
            .POS(j)
        ) u_cell (
            .aclk      (aclk),
            .shift_en  (s_fire),
            .sym_in    (chain[j]),
            .motif_len (len_eff),
            .motif_lo  (motif_lo_reg),
            .motif_hi  (motif_hi_reg),
            .sym_out   (chain[j+1]),
            .match     (cell_match[j])
        );
    end

    // Count a hit only for a non-empty motif whose window lies inside the sequence.
    assign hit = (&cell_match) && (len_eff != '0)
              && ((wmm_pkg::LEN_W + 1)'(count_reg) >= {1'b0, len_eff});

    assign ctl.valid = stage_valid_reg;
    assign ctl.eos   = stage_eos_reg;
    assign ctl.eset  = stage_eset_reg;

    wmm_tally #(
        .SEQUENCE_MAX (SEQUENCE_MAX),
        .HITS_W       (HITS_W)
    ) u_tally (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .ctl                 (ctl),
        .hit                 (hit),
        .stall               (stall),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_sequence_hits     (m_sequence_hits),
        .m_sequence_covered  (m_sequence_covered),
        .m_total_hits        (m_total_hits),
        .m_covered_sequences (m_covered_sequences),
        .m_seen_sequences    (m_seen_sequences)
    );

    a_count_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_SAT)
        else $error("symbol count above cell count");

    a_stall_needs_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && stage_valid_reg && stage_eos_reg))
        else $error("input stalled without a pending report");

    a_stage_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && stall) |=> (stage_valid_reg && $stable(stage_eos_reg)
                                        && $stable(stage_eset_reg)))
        else $error("stalled window stage lost its transaction");

endmodule

### bench/tb.sv
// Self-checking testbench of the wildcard motif match counter unit.
`timescale 1ns / 1ps
module tb;

    // Result width of the unit with its default parameters.
    localparam int HITS_W           = 13;
    localparam int WINDOW_DEPTH     = 16;
    localparam int SEQ_HIT_CAP      = 4096;
    localparam int RANDOM_ITEMS     = 1730;
    localparam int IDLE_LIMIT       = 5000;
    localparam int DRAIN_CYCLES     = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT     = 10;

    // Register index outside the map; the unit must drop writes to it.
    localparam logic [wmm_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

    localparam logic [wmm_pkg::SYM_W-1:0] SYM_A = 8'h41;
    localparam logic [wmm_pkg::SYM_W-1:0] SYM_C = 8'h43;
    localparam logic [wmm_pkg::SYM_W-1:0] SYM_G = 8'h47;
    localparam logic [wmm_pkg::SYM_W-1:0] SYM_T = 8'h54;

    typedef struct packed {
        logic [HITS_W-1:0]             seq_hits;
        logic                          covered;
        logic [wmm_pkg::TOTAL_W-1:0]   total_hits;
        logic [wmm_pkg::SET_CNT_W-1:0] covered_seqs;
        logic [wmm_pkg::SET_CNT_W-1:0] seen_seqs;
    } tally_t;

    // Receiver stall patterns.
    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_ALTERNATE,
        RX_SPARSE,
        RX_TRICKLE
    } rx_mode_t;

    // Tracks the motif registers, the symbol window and the set totals, and
    // holds the per-sequence tallies still owed by the unit.
    class motif_tally_board;
        logic [wmm_pkg::CFG_W-1:0] motif_lo;
        logic [wmm_pkg::CFG_W-1:0] motif_hi;
        logic [wmm_pkg::LEN_W-1:0] motif_len;
        logic [wmm_pkg::SYM_W-1:0] recent [WINDOW_DEPTH];
        int unsigned               seq_fill;
        int unsigned               seq_hits;
        int unsigned               set_hits;
        int unsigned               set_covered;
        int unsigned               set_seen;
        tally_t                    owed_tallies[$];
        int unsigned               mismatches;

        function new();
            motif_lo    = '0;
            motif_hi    = '0;
            motif_len   = 5'd1;
            foreach (recent[k]) recent[k] = '0;
            seq_fill    = 0;
            seq_hits    = 0;
            set_hits    = 0;
            set_covered = 0;
            set_seen    = 0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [wmm_pkg::CFG_ADDR_W-1:0] idx,
                                   logic [wmm_pkg::CFG_W-1:0] data);
            case (idx)
                wmm_pkg::REG_MOTIF_LOW:  motif_lo  = data;
                wmm_pkg::REG_MOTIF_HIGH: motif_hi  = data;
                wmm_pkg::REG_MOTIF_LEN:  motif_len = data[wmm_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [wmm_pkg::SYM_W-1:0] motif_at(int unsigned pos);
            if (pos < 8) return motif_lo[8*pos +: 8];
            return motif_hi[8*(pos-8) +: 8];
        endfunction

        // Motif character 0 lines up with the oldest symbol of the window.
        function bit window_hit(int unsigned span);
            logic [wmm_pkg::SYM_W-1:0] ch;
            for (int unsigned k = 0; k < span; k++) begin
                ch = motif_at(k);
                if (ch != wmm_pkg::WILDCARD && ch != recent[span-1-k]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_symbol(logic [wmm_pkg::SYM_W-1:0] sym, logic eos, logic eset);
            int unsigned     span;
            longint unsigned sum;
            tally_t          t;
            span = (motif_len > WINDOW_DEPTH) ? WINDOW_DEPTH : motif_len;
            for (int k = WINDOW_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
            recent[0] = sym;
            if (seq_fill < WINDOW_DEPTH) seq_fill++;
            if (span > 0 && seq_fill >= span && window_hit(span) && seq_hits < SEQ_HIT_CAP)
                seq_hits++;
            if (!eos) return;

            sum = longint'(set_hits) + seq_hits;
            set_hits = (sum > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
            if (seq_hits != 0 && set_covered < 16'hFFFF) set_covered++;
            if (set_seen < 16'hFFFF) set_seen++;

            t.seq_hits     = HITS_W'(seq_hits);
            t.covered      = (seq_hits != 0);
            t.total_hits   = set_hits;
            t.covered_seqs = wmm_pkg::SET_CNT_W'(set_covered);
            t.seen_seqs    = wmm_pkg::SET_CNT_W'(set_seen);
            owed_tallies.push_back(t);

            seq_fill = 0;
            seq_hits = 0;
            if (eset) begin
                set_hits    = 0;
                set_covered = 0;
                set_seen    = 0;
            end
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] %s: expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_tally(tally_t got);
            tally_t want;
            if (owed_tallies.size() == 0) begin
                flag("unexpected result, sequence_hits", 0, got.seq_hits);
                return;
            end
            want = owed_tallies.pop_front();
            if (got.seq_hits !== want.seq_hits)
                flag("sequence_hits", want.seq_hits, got.seq_hits);
            if (got.covered !== want.covered)
                flag("sequence_covered", want.covered, got.covered);
            if (got.total_hits !== want.total_hits)
                flag("total_hits", want.total_hits, got.total_hits);
            if (got.covered_seqs !== want.covered_seqs)
                flag("covered_sequences", want.covered_seqs, got.covered_seqs);
            if (got.seen_seqs !== want.seen_seqs)
                flag("seen_sequences", want.seen_seqs, got.seen_seqs);
        endfunction

        function int unsigned pending();
            return owed_tallies.size();
        endfunction
    endclass

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;

    logic                           cfg_wr_en   = 1'b0;
    logic [wmm_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [wmm_pkg::CFG_W-1:0]      cfg_wr_data = '0;

    logic                           s_valid           = 1'b0;
    logic                           s_ready;
    logic [wmm_pkg::SYM_W-1:0]      s_symbol          = '0;
    logic                           s_end_of_sequence = 1'b0;
    logic                           s_end_of_set      = 1'b0;

    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [HITS_W-1:0]              m_sequence_hits;
    logic                           m_sequence_covered;
    logic [wmm_pkg::TOTAL_W-1:0]    m_total_hits;
    logic [wmm_pkg::SET_CNT_W-1:0]  m_covered_sequences;
    logic [wmm_pkg::SET_CNT_W-1:0]  m_seen_sequences;

    motif_tally_board board = new();

    always #10 aclk = ~aclk;

    wildcard_motif_match_counter_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_symbol           (s_symbol),
        .s_end_of_sequence  (s_end_of_sequence),
        .s_end_of_set       (s_end_of_set),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sequence_hits    (m_sequence_hits),
        .m_sequence_covered (m_sequence_covered),
        .m_total_hits       (m_total_hits),
        .m_covered_sequences(m_covered_sequences),
        .m_seen_sequences   (m_seen_sequences)
    );

    // Monitor: sample both channels on the edge, before the unit's own updates land.
    // Check the result first; it always belongs to an older symbol.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_tally({m_sequence_hits, m_sequence_covered, m_total_hits,
                                   m_covered_sequences, m_seen_sequences});
            if (s_valid && s_ready)
                board.note_symbol(s_symbol, s_end_of_sequence, s_end_of_set);
        end
    end

    // Watchdog: end the run once no transaction moves on either channel for too long.
    int unsigned idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: switch between randomly chosen stall patterns. A toggle of
    // hold_off_go from the stimulus starts a long hold-off, counted here.
    logic        hold_off_go   = 1'b0;
    logic        hold_off_seen = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned mode_left     = 0;
    rx_mode_t    rx_mode       = RX_OPEN;
    logic [1:0]  rx_tick       = '0;

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_go != hold_off_seen) begin
            hold_off_seen <= hold_off_go;
            hold_left     <= LONG_HOLD_CYCLES;
            m_ready       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(32, 400);
                rx_mode   <= rx_mode_t'($urandom_range(0, 4));
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:      m_ready <= 1'b1;
                RX_MOSTLY:    m_ready <= ($urandom_range(0, 3) != 0);
                RX_ALTERNATE: m_ready <= !m_ready;
                RX_SPARSE:    m_ready <= (rx_tick == 2'd0);
                default:      m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Sender state: symbols left in the current burst.
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;

    function automatic logic [wmm_pkg::SYM_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return SYM_A;
            1:       return SYM_C;
            2:       return SYM_G;
            default: return SYM_T;
        endcase
    endfunction

    // Mostly a four-letter alphabet so that hits are common; now and then the dash
    // itself or any byte at all.
    function automatic logic [wmm_pkg::SYM_W-1:0] pick_symbol();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14) return pick_base();
        if (r < 16) return wmm_pkg::WILDCARD;
        return wmm_pkg::SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [wmm_pkg::CFG_W-1:0] pick_motif_word();
        logic [wmm_pkg::CFG_W-1:0] w;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 6))
                0, 1:    w[8*k +: 8] = wmm_pkg::WILDCARD;
                2:       w[8*k +: 8] = wmm_pkg::SYM_W'($urandom_range(0, 255));
                default: w[8*k +: 8] = pick_base();
            endcase
        end
        return w;
    endfunction

    // Offer one symbol and hold it until the unit takes it. Open a random gap
    // first whenever a burst runs out; the odd long burst gives stretches
    // with no idling at all.
    task automatic push_symbol(input logic [wmm_pkg::SYM_W-1:0] sym, input logic eos,
                               input logic eset);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_symbol          <= sym;
        s_end_of_sequence <= eos;
        s_end_of_set      <= eset;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering, wait for every owed result, then let the pipeline empty of
    // symbols that produce none.
    task automatic settle();
        s_valid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the three motif registers back to back; call only while the unit is idle.
    // Fill the unused upper bits of the length write with noise.
    task automatic program_motif(input logic [wmm_pkg::CFG_W-1:0] lo,
                                 input logic [wmm_pkg::CFG_W-1:0] hi,
                                 input logic [wmm_pkg::LEN_W-1:0] len,
                                 input bit poke_unmapped);
        logic [wmm_pkg::CFG_W-1:0] len_word;
        len_word                     = {$urandom, $urandom};
        len_word[wmm_pkg::LEN_W-1:0] = len;
        cfg_wr_en <= 1'b1;
        if (poke_unmapped) begin
            cfg_addr    <= REG_UNMAPPED;
            cfg_wr_data <= {$urandom, $urandom};
            @(posedge aclk);
        end
        cfg_addr    <= wmm_pkg::REG_MOTIF_LOW;
        cfg_wr_data <= lo;
        board.set_register(wmm_pkg::REG_MOTIF_LOW, lo);
        @(posedge aclk);
        cfg_addr    <= wmm_pkg::REG_MOTIF_HIGH;
        cfg_wr_data <= hi;
        board.set_register(wmm_pkg::REG_MOTIF_HIGH, hi);
        @(posedge aclk);
        cfg_addr    <= wmm_pkg::REG_MOTIF_LEN;
        cfg_wr_data <= len_word;
        board.set_register(wmm_pkg::REG_MOTIF_LEN, len_word);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Send one sequence of n symbols. Plant copies of the motif (wildcards filled
    // at random) so that long motifs still hit; sprinkle end_of_set without
    // end_of_sequence as noise.
    task automatic send_sequence(input int unsigned n, input logic eset, input int unsigned span);
        int unsigned               plant_pos;
        bit                        planting;
        logic [wmm_pkg::SYM_W-1:0] sym;
        logic [wmm_pkg::SYM_W-1:0] ch;
        logic                      last;
        planting  = 1'b0;
        plant_pos = 0;
        for (int unsigned k = 0; k < n; k++) begin
            if (!planting && span != 0 && $urandom_range(0, 2) == 0) begin
                planting  = 1'b1;
                plant_pos = 0;
            end
            if (planting) begin
                ch  = board.motif_at(plant_pos);
                sym = (ch == wmm_pkg::WILDCARD) ? pick_symbol() : ch;
                plant_pos++;
                if (plant_pos >= span) planting = 1'b0;
            end else begin
                sym = pick_symbol();
            end
            last = (k == n - 1);
            push_symbol(sym, last, last ? eset : ($urandom_range(0, 39) == 0));
            items_sent++;
        end
    endtask

    initial begin
        int unsigned               phase;
        int unsigned               target;
        int unsigned               n;
        int unsigned               span;
        logic [wmm_pkg::LEN_W-1:0] len;
        logic [wmm_pkg::CFG_W-1:0] lo;
        logic [wmm_pkg::CFG_W-1:0] hi;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset motif is one character of code zero: symbol zero hits, 0xFF does not.
        push_symbol(8'h00, 1'b1, 1'b0);
        push_symbol(8'hFF, 1'b1, 1'b1);
        settle();

        // Motif A-CG with all-ones filler; poke the unmapped index on the way.
        program_motif(64'hFFFF_FFFF_4743_2D41, '1, 5'd4, 1'b1);
        // Overlapping-window sequence with one set marker that carries no end of sequence.
        push_symbol(SYM_A, 1'b0, 1'b0);
        push_symbol(SYM_T, 1'b0, 1'b1);
        push_symbol(SYM_C, 1'b0, 1'b0);
        push_symbol(SYM_G, 1'b0, 1'b0);
        push_symbol(SYM_C, 1'b0, 1'b0);
        push_symbol(SYM_G, 1'b1, 1'b0);
        // Shorter than the motif: no hit, even though the window holds earlier symbols.
        push_symbol(SYM_C, 1'b0, 1'b0);
        push_symbol(SYM_G, 1'b1, 1'b1);
        settle();

        // Zero length: nothing matches.
        program_motif(64'h2D2D_2D2D_2D2D_2D2D, '0, 5'd0, 1'b0);
        push_symbol(SYM_A, 1'b1, 1'b0);
        settle();

        // Largest length, all wildcards: clamps to sixteen, so three symbols give no hit.
        program_motif(64'h2D2D_2D2D_2D2D_2D2D, 64'h2D2D_2D2D_2D2D_2D2D, 5'd31, 1'b0);
        push_symbol(SYM_T, 1'b0, 1'b0);
        push_symbol(SYM_G, 1'b0, 1'b0);
        push_symbol(8'hFF, 1'b1, 1'b1);
        settle();

        // Rewrite the motif in mid-sequence; the symbols already taken still count.
        program_motif(64'h0000_0000_0000_0041, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1, 1'b0);
        push_symbol(SYM_A, 1'b0, 1'b0);
        push_symbol(SYM_C, 1'b0, 1'b0);
        settle();
        program_motif(64'h0000_0000_0000_4143, '0, 5'd2, 1'b0);
        push_symbol(SYM_A, 1'b1, 1'b0);
        push_symbol(SYM_A, 1'b1, 1'b1);
        settle();

        // Random phases, each under a fresh motif. Phase two runs short sequences
        // under a long receiver hold-off so the unit fills and stalls its input.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 9))
                0:       len = 5'd0;
                1:       len = 5'd1;
                2:       len = 5'd16;
                3:       len = wmm_pkg::LEN_W'($urandom_range(17, 31));
                default: len = wmm_pkg::LEN_W'($urandom_range(2, 15));
            endcase
            if ($urandom_range(0, 7) == 0) begin
                lo = '1;
                hi = '0;
            end else begin
                lo = pick_motif_word();
                hi = pick_motif_word();
            end
            program_motif(lo, hi, len, (phase % 3) == 0);
            span = (len > WINDOW_DEPTH) ? WINDOW_DEPTH : len;
            if (phase == 2) hold_off_go <= ~hold_off_go;
            target = items_sent + $urandom_range(80, 160);
            while (items_sent < target) begin
                if (phase == 2) begin
                    n = $urandom_range(1, 2);
                end else if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(20, 80);
                end else begin
                    n = $urandom_range(1, span + 6);
                end
                send_sequence(n, $urandom_range(0, 4) == 0, span);
            end
            phase++;
        end
        settle();

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
